// ----- design/shpr_pkg.sv -----
`timescale 1ns / 1ps
package shpr_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [4:0] script_index;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       final_res;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_VERSION, PH_INCOUNT, PH_OUTPOINT, PH_SIGLEN, PH_SIGSKIP, PH_SEQUENCE,
    PH_OUTCOUNT, PH_VALUE, PH_SPKLEN, PH_SPK, PH_LOCKTIME
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_TRUNC = 2'd1, ST_VARINT = 2'd2, ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    EM_IDLE, EM_PRE, EM_RD, EM_SCR
  } emit_e;

  localparam logic [1:0] CFG_INPUT_INDEX   = 2'd0;
  localparam logic [1:0] CFG_SCRIPT_LENGTH = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_LIMIT  = 2'd2;

  localparam logic [7:0] VARINT_FD     = 8'hFD;
  localparam logic [7:0] HASHTYPE_BYTE = 8'h01;
  localparam int unsigned OUTPOINT_LEN = 36;
  localparam int unsigned VALUE_LEN    = 8;
  localparam int unsigned WORD_LEN     = 4;
  localparam int unsigned PRE_MAX      = 5;

endpackage

// ----- design/sighash_preimage_rewriter.sv -----
`timescale 1ns / 1ps
// Legacy signature-hash preimage streamer. Transaction bytes (kind 1) and signing
// script loads (kind 0) arrive on the input channel; preimage bytes leave on
// the output channel, the last one of a job flagged by final_res, or a single
// error result with a nonzero status. The block parses one item at a time:
// it accepts no new item until every result byte that the last one caused
// has entered the output register, and each inserted script byte is first
// read from the script memory into a register before it is sent.
// Loads and writes of the configuration port should happen while no result
// is pending.
module sighash_preimage_rewriter #(
  parameter int SCRIPT_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  shpr_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output shpr_pkg::out_item_t  out_data_o
);

  localparam int AW = (SCRIPT_BYTES > 1) ? $clog2(SCRIPT_BYTES) : 1;

  // configuration
  logic [7:0]  input_index_q;
  logic [5:0]  script_length_q;
  logic [15:0] output_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_index_q   <= 8'd0;
      script_length_q <= 6'd25;
      output_limit_q  <= 16'd1312;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        shpr_pkg::CFG_INPUT_INDEX:   input_index_q   <= cfg_data_i[7:0];
        shpr_pkg::CFG_SCRIPT_LENGTH: script_length_q <= cfg_data_i[5:0];
        shpr_pkg::CFG_OUTPUT_LIMIT:  output_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser state
  shpr_pkg::phase_e phase_q, phase_d;
  logic [15:0] fc_q, fc_d, vv_q, vv_d, it_q, it_d, ic_q, ic_d, ot_q, ot_d, oc_q, oc_d;
  logic [15:0] wl_q, wl_d;
  logic [1:0]  vb_q, vb_d;
  logic        jd_q, jd_d;

  // emission plan and sequencer
  shpr_pkg::emit_e em_q, em_d;
  logic [7:0]  pre_q [shpr_pkg::PRE_MAX];
  logic [2:0]  pre_n_q, pi_q;
  logic [5:0]  scr_n_q, k_q;
  logic [1:0]  st_q;
  logic        fin_q;

  logic        out_valid_q;
  shpr_pkg::out_item_t out_q;

  logic [7:0]  mem [SCRIPT_BYTES];
  logic [7:0]  rd_q;

  logic in_acc, tx_acc, slot_free;
  assign in_ready_o = (em_q == shpr_pkg::EM_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign tx_acc     = in_acc && in_data_i.kind;
  assign slot_free  = !out_valid_q || out_ready_i;

  // script memory: write on loads, read at the sequencer count
  logic [AW+5:0] widx;
  assign widx = {{(AW+1){1'b0}}, in_data_i.script_index};

  always_ff @(posedge clk_i) begin
    if (in_acc && !in_data_i.kind && (int'(in_data_i.script_index) < SCRIPT_BYTES)) begin
      mem[widx[AW-1:0]] <= in_data_i.data;
    end
    rd_q <= mem[k_q[AW-1:0]];
  end

  // parse one transaction byte
  logic [7:0]  b;
  logic [7:0]  pre_d [shpr_pkg::PRE_MAX];
  logic [2:0]  pre_n;
  logic [5:0]  scr_n, sn;
  logic [1:0]  vb_t;
  logic [15:0] vv_t, vval, fc_inc, fc_dec, evval;
  logic        vdone, verr, ps, ev, ovf;
  logic [6:0]  total;
  shpr_pkg::status_e err;
  int unsigned len;

  assign b = in_data_i.data;
  assign sn = (int'(script_length_q) > SCRIPT_BYTES) ? 6'(SCRIPT_BYTES) : script_length_q;

  always_comb begin
    vb_t = vb_q; vv_t = vv_q; vval = vv_q; vdone = 1'b0; verr = 1'b0;
    case (vb_q)
      2'd0: begin
        if (b < shpr_pkg::VARINT_FD) begin
          vval = {8'd0, b}; vdone = 1'b1;
        end else if (b == shpr_pkg::VARINT_FD) begin
          vb_t = 2'd1;
        end else begin
          verr = 1'b1;
        end
      end
      2'd1: begin
        vv_t = {8'd0, b}; vb_t = 2'd2;
      end
      default: begin
        vval = {b, vv_q[7:0]}; vv_t = vval; vb_t = 2'd0; vdone = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q; fc_d = fc_q; vv_d = vv_q; vb_d = vb_q;
    it_d = it_q; ic_d = ic_q; ot_d = ot_q; oc_d = oc_q; jd_d = jd_q;
    for (int i = 0; i < shpr_pkg::PRE_MAX; i++) pre_d[i] = 8'd0;
    pre_n = 3'd0; scr_n = 6'd0; err = shpr_pkg::ST_OK;
    ps = 1'b0; ev = 1'b0; evval = vval;
    fc_inc = fc_q + 16'd1;
    fc_dec = fc_q - 16'd1;
    len = (phase_q == shpr_pkg::PH_OUTPOINT) ? shpr_pkg::OUTPOINT_LEN :
          (phase_q == shpr_pkg::PH_VALUE) ? shpr_pkg::VALUE_LEN : shpr_pkg::WORD_LEN;
    case (phase_q)
      shpr_pkg::PH_VERSION, shpr_pkg::PH_OUTPOINT, shpr_pkg::PH_SEQUENCE,
      shpr_pkg::PH_VALUE, shpr_pkg::PH_LOCKTIME: begin
        pre_d[0] = b; pre_n = 3'd1;
        if (int'(fc_inc) < len) begin
          fc_d = fc_inc;
        end else begin
          fc_d = 16'd0;
          case (phase_q)
            shpr_pkg::PH_VERSION:  phase_d = shpr_pkg::PH_INCOUNT;
            shpr_pkg::PH_OUTPOINT: phase_d = shpr_pkg::PH_SIGLEN;
            shpr_pkg::PH_SEQUENCE: begin
              ic_d = ic_q + 16'd1;
              phase_d = (ic_d == it_q) ? shpr_pkg::PH_OUTCOUNT : shpr_pkg::PH_OUTPOINT;
            end
            shpr_pkg::PH_VALUE: phase_d = shpr_pkg::PH_SPKLEN;
            default: begin
              pre_d[1] = shpr_pkg::HASHTYPE_BYTE; pre_n = 3'd5; jd_d = 1'b1;
            end
          endcase
        end
      end
      shpr_pkg::PH_SIGSKIP: begin
        fc_d = fc_dec;
        ps = (fc_dec == 16'd0);
      end
      shpr_pkg::PH_SPK: begin
        pre_d[0] = b; pre_n = 3'd1;
        fc_d = fc_dec;
        if (fc_dec == 16'd0) begin
          oc_d = oc_q + 16'd1;
          phase_d = (oc_d == ot_q) ? shpr_pkg::PH_LOCKTIME : shpr_pkg::PH_VALUE;
        end
      end
      default: begin
        vb_d = vb_t; vv_d = vv_t;
        if (verr) begin
          err = shpr_pkg::ST_VARINT;
        end else if (vdone) begin
          fc_d = 16'd0;
          case (phase_q)
            shpr_pkg::PH_INCOUNT: begin
              it_d = vval; ic_d = 16'd0; ev = 1'b1;
              phase_d = (vval != 16'd0) ? shpr_pkg::PH_OUTPOINT : shpr_pkg::PH_OUTCOUNT;
            end
            shpr_pkg::PH_SIGLEN: begin
              fc_d = vval;
              if (vval == 16'd0) ps = 1'b1;
              else phase_d = shpr_pkg::PH_SIGSKIP;
            end
            shpr_pkg::PH_OUTCOUNT: begin
              ot_d = vval; oc_d = 16'd0; ev = 1'b1;
              phase_d = (vval != 16'd0) ? shpr_pkg::PH_VALUE : shpr_pkg::PH_LOCKTIME;
            end
            default: begin
              ev = 1'b1; fc_d = vval;
              if (vval == 16'd0) begin
                oc_d = oc_q + 16'd1;
                phase_d = (oc_d == ot_q) ? shpr_pkg::PH_LOCKTIME : shpr_pkg::PH_VALUE;
              end else begin
                phase_d = shpr_pkg::PH_SPK;
              end
            end
          endcase
        end
      end
    endcase
    // insert the signing script or an empty script
    if (ps) begin
      pre_n = 3'd1;
      if (ic_q == {8'd0, input_index_q}) begin
        pre_d[0] = {2'd0, sn}; scr_n = sn;
      end else begin
        pre_d[0] = 8'd0;
      end
      phase_d = shpr_pkg::PH_SEQUENCE; fc_d = 16'd0;
    end
    // canonical compact size
    if (ev) begin
      if (evval < {8'd0, shpr_pkg::VARINT_FD}) begin
        pre_d[0] = evval[7:0]; pre_n = 3'd1;
      end else begin
        pre_d[0] = shpr_pkg::VARINT_FD; pre_d[1] = evval[7:0]; pre_d[2] = evval[15:8];
        pre_n = 3'd3;
      end
    end
    // overflow only when this byte actually sends something
    total = {4'd0, pre_n} + {1'b0, scr_n};
    ovf = (total != 7'd0) &&
          (({1'b0, wl_q} + {10'd0, total}) > {1'b0, output_limit_q});
    if (err == shpr_pkg::ST_OK && ovf) err = shpr_pkg::ST_OVERFLOW;
    if (err == shpr_pkg::ST_OK && in_data_i.last && !jd_d) err = shpr_pkg::ST_TRUNC;
    wl_d = wl_q + {9'd0, total};
  end

  // parser state update on transaction transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= shpr_pkg::PH_VERSION;
      fc_q <= '0; vv_q <= '0; vb_q <= '0; it_q <= '0; ic_q <= '0;
      ot_q <= '0; oc_q <= '0; wl_q <= '0; jd_q <= 1'b0;
    end else if (tx_acc) begin
      if (in_data_i.last && (jd_q || err != shpr_pkg::ST_OK || jd_d)) begin
        phase_q <= shpr_pkg::PH_VERSION;
        fc_q <= '0; vv_q <= '0; vb_q <= '0; it_q <= '0; ic_q <= '0;
        ot_q <= '0; oc_q <= '0; wl_q <= '0; jd_q <= 1'b0;
      end else if (jd_q) begin
        jd_q <= 1'b1;
      end else if (err != shpr_pkg::ST_OK) begin
        jd_q <= 1'b1;
      end else begin
        phase_q <= phase_d;
        fc_q <= fc_d; vv_q <= vv_d; vb_q <= vb_d; it_q <= it_d; ic_q <= ic_d;
        ot_q <= ot_d; oc_q <= oc_d; wl_q <= wl_d; jd_q <= jd_d;
      end
    end
  end

  // latch the emission plan
  logic plan_go;
  assign plan_go = tx_acc && !jd_q && ((err != shpr_pkg::ST_OK) || (pre_n != 3'd0));

  always_ff @(posedge clk_i) begin
    if (plan_go) begin
      if (err != shpr_pkg::ST_OK) begin
        for (int i = 0; i < shpr_pkg::PRE_MAX; i++) pre_q[i] <= 8'd0;
        pre_n_q <= 3'd1; scr_n_q <= 6'd0; st_q <= err; fin_q <= 1'b1;
      end else begin
        pre_q <= pre_d;
        pre_n_q <= pre_n; scr_n_q <= scr_n; st_q <= shpr_pkg::ST_OK; fin_q <= jd_d;
      end
    end
  end

  // sequencer next state
  always_comb begin
    em_d = em_q;
    case (em_q)
      shpr_pkg::EM_IDLE: if (plan_go) em_d = shpr_pkg::EM_PRE;
      shpr_pkg::EM_PRE: begin
        if (slot_free && (pi_q == pre_n_q - 3'd1)) begin
          em_d = (scr_n_q != 6'd0) ? shpr_pkg::EM_RD : shpr_pkg::EM_IDLE;
        end
      end
      shpr_pkg::EM_RD: em_d = shpr_pkg::EM_SCR;
      shpr_pkg::EM_SCR: begin
        if (slot_free) begin
          em_d = (k_q == scr_n_q - 6'd1) ? shpr_pkg::EM_IDLE : shpr_pkg::EM_RD;
        end
      end
      default: em_d = shpr_pkg::EM_IDLE;
    endcase
  end

  // sequencer outputs: which byte enters the output register
  logic      load;
  shpr_pkg::out_item_t load_item;
  always_comb begin
    load = 1'b0;
    load_item = '0;
    case (em_q)
      shpr_pkg::EM_PRE: begin
        load = slot_free;
        load_item.out_byte  = pre_q[pi_q];
        load_item.status    = st_q;
        load_item.final_res = fin_q && (pi_q == pre_n_q - 3'd1) && (scr_n_q == 6'd0);
      end
      shpr_pkg::EM_SCR: begin
        load = slot_free;
        load_item.out_byte  = rd_q;
        load_item.status    = st_q;
        load_item.final_res = fin_q && (k_q == scr_n_q - 6'd1);
      end
      default: ;
    endcase
  end

  // advance counters and hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_q <= shpr_pkg::EM_IDLE;
      pi_q <= '0;
      k_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      em_q <= em_d;
      if (plan_go) begin
        pi_q <= '0;
        k_q <= '0;
      end else if (load && em_q == shpr_pkg::EM_PRE) begin
        pi_q <= pi_q + 3'd1;
      end else if (load && em_q == shpr_pkg::EM_SCR) begin
        k_q <= k_q + 6'd1;
      end
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= load_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/shpr_checker.sv -----
`timescale 1ns / 1ps
module shpr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input shpr_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input shpr_pkg::out_item_t out_data_o
);

  // an error result is a lone final zero byte
  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != shpr_pkg::ST_OK |->
      out_data_o.final_res && out_data_o.out_byte == 8'd0)
    else $error("error result not final or not zero");

  // a script load causes no results and keeps the input open
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.kind |=> in_ready_o)
    else $error("script load blocked the input");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind sighash_preimage_rewriter shpr_checker u_shpr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
